// ===== src/atsg_pkg.sv =====
// Shared types and constants of the sine PWM compare generator.
package atsg_pkg;

  localparam int unsigned CMP_W   = 9;
  localparam int unsigned STEP_W  = 15;
  localparam int unsigned OUT_TDW = 40;

  localparam int unsigned DIV_QW = 16;
  localparam int unsigned DIV_DW = 15;
  localparam int unsigned DIV_NW = 31;

  localparam logic [STEP_W-1:0] SCALE_RST    = 15'd18000;
  localparam logic [STEP_W-1:0] MIN_STEP_RST = 15'd360;
  localparam logic [CMP_W-1:0]  MAX_CMP_RST  = 9'd444;
  localparam int unsigned       LOW_RST      = 256;
  localparam int unsigned       HIGH_RST     = 512;

  typedef enum logic [1:0] {
    CFG_PERIOD_SCALE = 2'd0,
    CFG_MIN_STEPS    = 2'd1,
    CFG_MAX_COMPARE  = 2'd2
  } cfg_index_e;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_TICK   = 1'b1
  } item_kind_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SAMP_MUL,
    BK_SAMP_DIV,
    BK_SAMP_OUT,
    BK_TICK_DIV,
    BK_TICK_ROM,
    BK_TICK_MUL,
    BK_TICK_FIN
  } back_state_e;

  typedef struct packed {
    logic [STEP_W-1:0] period_scale;
    logic [STEP_W-1:0] min_steps;
    logic [CMP_W-1:0]  max_compare;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_QW-1:0] quo;
  } div_rsp_t;

endpackage

// ===== src/adc_tuned_sine_pwm_generator_top.sv =====
// Top level of the ADC-tuned sine PWM compare generator.
// Every input word yields one output word, in order. A carrier tick word (tuser = 1) gets its
// compare pair as soon as the back end takes it; the back end then stays busy while the
// 16-step shared divider turns the phase into a table position, followed by the registered
// sine ROM read, the scaling multiply and the final subtract. An ADC sample word (tuser = 0)
// likewise keeps the back end busy through that divider; its result carries the new
// steps-per-period and zero compares. A two-word queue in front keeps the input side open
// while the back end works, and the output register lets a following sample word start while
// a result waits. Configuration writes are always accepted and are meant for idle times.
module adc_tuned_sine_pwm_generator_top import atsg_pkg::*; #(
  parameter int unsigned SINE_ENTRIES = 1024,
  parameter int unsigned SAMPLE_BITS  = 10
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // adc_sample
  input  logic [0:0]                            s_axis_tuser,  // func
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [OUT_TDW-1:0]                    m_axis_tdata,  // compare_a, compare_b,
                                                               // steps_per_period
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [1:0]                            cfg_index_i,
  input  logic [STEP_W-1:0]                     cfg_data_i
);

  cfg_t                   cfg_q;
  logic                   q_valid, q_pop;
  item_kind_e             q_kind;
  logic [SAMPLE_BITS-1:0] q_sample;
  div_req_t               div_req;
  div_rsp_t               div_rsp;
  logic [CMP_W-1:0]       out_ca, out_cb;
  logic [STEP_W-1:0]      out_steps;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{period_scale: SCALE_RST, min_steps: MIN_STEP_RST, max_compare: MAX_CMP_RST};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PERIOD_SCALE: cfg_q.period_scale <= cfg_data_i;
        CFG_MIN_STEPS:    cfg_q.min_steps    <= cfg_data_i;
        CFG_MAX_COMPARE:  cfg_q.max_compare  <= cfg_data_i[CMP_W-1:0];
        default: ;
      endcase
    end
  end

  atsg_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_func_i  (s_axis_tuser[0]),
    .in_sample_i(s_axis_tdata[SAMPLE_BITS-1:0]),
    .pop_i      (q_pop),
    .q_valid_o  (q_valid),
    .q_kind_o   (q_kind),
    .q_sample_o (q_sample)
  );

  atsg_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  atsg_back #(
    .SINE_ENTRIES(SINE_ENTRIES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_kind_i   (q_kind),
    .q_sample_i (q_sample),
    .q_pop_o    (q_pop),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_ca_o   (out_ca),
    .out_cb_o   (out_cb),
    .out_steps_o(out_steps)
  );

  assign m_axis_tdata = {(OUT_TDW - 2 * CMP_W - STEP_W)'(0), out_steps, out_cb, out_ca};

endmodule

// ===== src/atsg_front.sv =====
// Input side: accepts words, tags their kind and queues them for the back end.
module atsg_front import atsg_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   in_func_i,
  input  logic [SAMPLE_BITS-1:0] in_sample_i,
  input  logic                   pop_i,
  output logic                   q_valid_o,
  output item_kind_e             q_kind_o,
  output logic [SAMPLE_BITS-1:0] q_sample_o
);

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned PW     = $clog2(QDEPTH);
  localparam int unsigned CW     = $clog2(QDEPTH + 1);

  item_kind_e             kind_q   [QDEPTH];
  logic [SAMPLE_BITS-1:0] sample_q [QDEPTH];
  logic [PW-1:0]          wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]          count_q, count_d;
  logic                   push, pop;

  assign in_ready_o = (count_q != CW'(QDEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != '0);
  assign pop        = pop_i && q_valid_o;
  assign q_kind_o   = kind_q[rd_ptr_q];
  assign q_sample_o = sample_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      kind_q[wr_ptr_q]   <= in_func_i ? KIND_TICK : KIND_SAMPLE;
      sample_q[wr_ptr_q] <= in_sample_i;
    end
  end

endmodule

// ===== src/atsg_div.sv =====
// Restoring divider, one quotient bit per cycle.
module atsg_div import atsg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(DIV_QW);

  logic              busy_q, busy_d, done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIV_NW-1:0] rem_q, rem_d, dsh_q, dsh_d;
  logic [DIV_QW-1:0] quo_q, quo_d;
  logic              fits;

  assign fits = (rem_q >= dsh_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = req_i.num;
      dsh_d  = DIV_NW'({req_i.den, {(DIV_QW - 1){1'b0}}});
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? rem_q - dsh_q : rem_q;
      quo_d = {quo_q[DIV_QW-2:0], fits};
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DIV_QW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign rsp_o = '{done: done_q, quo: quo_q};

endmodule

// ===== src/atsg_back.sv =====
// Back end: range tracking, period update, phase stepping and compare lookup.
module atsg_back import atsg_pkg::*; #(
  parameter int unsigned SINE_ENTRIES = 1024,
  parameter int unsigned SAMPLE_BITS  = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  logic                   q_valid_i,
  input  item_kind_e             q_kind_i,
  input  logic [SAMPLE_BITS-1:0] q_sample_i,
  output logic                   q_pop_o,
  output div_req_t               div_req_o,
  input  div_rsp_t               div_rsp_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [CMP_W-1:0]       out_ca_o,
  output logic [CMP_W-1:0]       out_cb_o,
  output logic [STEP_W-1:0]      out_steps_o
);

  localparam int unsigned MW  = (SAMPLE_BITS > 10) ? SAMPLE_BITS : 10;
  localparam int unsigned KW  = $clog2(SINE_ENTRIES);
  localparam int unsigned KPW = 15 + $clog2(SINE_ENTRIES + 1);
  localparam int unsigned PRW = STEP_W + MW;
  localparam int unsigned MAGW = 15;

  localparam logic [63:0] PiQ30  = 64'd3373259426;
  localparam logic [63:0] OneQ30 = 64'd1073741824;
  localparam int unsigned SeriesDiv [12] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420,
                                             506, 600};

  // Q30 Taylor series, evaluated at elaboration only
  function automatic logic [MAGW-1:0] sine_entry(input int unsigned k);
    logic [63:0] m, x, x2, term, acc, q;
    m  = (k <= SINE_ENTRIES - k) ? 64'(k) : 64'(SINE_ENTRIES - k);
    x  = (PiQ30 * m) / SINE_ENTRIES;
    x2 = (x * x) >> 30;
    term = x;
    acc  = x;
    for (int i = 0; i < 12; i++) begin
      term = ((term * x2) >> 30) / SeriesDiv[i];
      acc  = (i % 2 == 0) ? acc - term : acc + term;
    end
    if (acc > OneQ30) begin
      acc = OneQ30;
    end
    q = (acc + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return q[MAGW-1:0];
  endfunction

  logic [MAGW-1:0] sine_rom [SINE_ENTRIES];

  for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_rom
    assign sine_rom[g] = sine_entry(g);
  end

  back_state_e       state_q, state_d;
  logic [MW-1:0]     low_q, low_d, high_q, high_d;
  logic [STEP_W-1:0] period_q, period_d, phase_q, phase_d;
  logic [CMP_W-1:0]  next_cmp_q, next_cmp_d;
  logic              out_valid_q, out_valid_d;
  logic [CMP_W-1:0]  ca_q, ca_d, cb_q, cb_d;
  logic [STEP_W-1:0] steps_q, steps_d;
  logic [MW-1:0]     sample_q, sample_d;
  logic              empty_q, empty_d, zero_q, zero_d;
  logic [KW-1:0]     addr_q, addr_d;
  logic [MAGW-1:0]   mag_q, mag_d;
  logic [CMP_W+MAGW-1:0] prod_q, prod_d;

  logic              slot_free, take;
  logic [MW-1:0]     s_ext;
  logic [PRW-1:0]    sprod;
  logic [STEP_W-1:0] phase_inc, phase_new, quo_sat;
  logic [DIV_QW-1:0] f;
  logic [KPW-1:0]    kprod;

  assign slot_free = !out_valid_q || out_ready_i;
  assign take      = q_valid_i && (q_kind_i == KIND_SAMPLE || slot_free);
  assign s_ext     = MW'(q_sample_i);
  assign sprod     = PRW'(cfg_i.period_scale) * PRW'(sample_q - low_q);
  assign phase_inc = phase_q + STEP_W'(1);
  assign phase_new = (phase_inc >= period_q) ? '0 : phase_inc;
  assign quo_sat   = div_rsp_i.quo[DIV_QW-1] ? '1 : div_rsp_i.quo[STEP_W-1:0];
  assign f         = zero_q ? '0 : div_rsp_i.quo;
  assign kprod     = KPW'(f[14:0]) * KPW'(SINE_ENTRIES);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (take) begin
          state_d = (q_kind_i == KIND_TICK) ? BK_TICK_DIV : BK_SAMP_MUL;
        end
      end
      BK_SAMP_MUL: state_d = BK_SAMP_DIV;
      BK_SAMP_DIV: begin
        if (div_rsp_i.done) begin
          state_d = BK_SAMP_OUT;
        end
      end
      BK_SAMP_OUT: begin
        if (slot_free) begin
          state_d = BK_IDLE;
        end
      end
      BK_TICK_DIV: begin
        if (div_rsp_i.done) begin
          state_d = BK_TICK_ROM;
        end
      end
      BK_TICK_ROM: state_d = BK_TICK_MUL;
      BK_TICK_MUL: state_d = BK_TICK_FIN;
      BK_TICK_FIN: state_d = BK_IDLE;
      default:     state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o     = 1'b0;
    div_req_o   = '{start: 1'b0, num: '0, den: '0};
    low_d       = low_q;
    high_d      = high_q;
    period_d    = period_q;
    phase_d     = phase_q;
    next_cmp_d  = next_cmp_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ca_d        = ca_q;
    cb_d        = cb_q;
    steps_d     = steps_q;
    sample_d    = sample_q;
    empty_d     = empty_q;
    zero_d      = zero_q;
    addr_d      = addr_q;
    mag_d       = mag_q;
    prod_d      = prod_q;
    unique case (state_q)
      BK_IDLE: begin
        if (take) begin
          q_pop_o = 1'b1;
          if (q_kind_i == KIND_SAMPLE) begin
            sample_d = s_ext;
            if (s_ext < low_q) begin
              low_d = s_ext;
            end
            if (s_ext > high_q) begin
              high_d = s_ext;
            end
          end else begin
            out_valid_d = 1'b1;
            steps_d     = period_q;
            if ({phase_q, 1'b0} < {1'b0, period_q}) begin
              ca_d = next_cmp_q;
              cb_d = cfg_i.max_compare;
            end else begin
              ca_d = cfg_i.max_compare;
              cb_d = next_cmp_q;
            end
            phase_d   = phase_new;
            zero_d    = (period_q == '0);
            div_req_o = '{start: 1'b1, num: DIV_NW'({phase_new, {DIV_QW{1'b0}}}),
                          den: DIV_DW'(period_q)};
          end
        end
      end
      BK_SAMP_MUL: begin
        empty_d   = (high_q <= low_q);
        div_req_o = '{start: 1'b1, num: DIV_NW'(sprod), den: DIV_DW'(high_q - low_q)};
      end
      BK_SAMP_DIV: begin
        if (div_rsp_i.done) begin
          if (empty_q || quo_sat <= cfg_i.min_steps) begin
            period_d = cfg_i.min_steps;
          end else begin
            period_d = quo_sat;
          end
        end
      end
      BK_SAMP_OUT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          ca_d        = '0;
          cb_d        = '0;
          steps_d     = period_q;
        end
      end
      BK_TICK_DIV: begin
        if (div_rsp_i.done) begin
          addr_d = kprod[15 +: KW];
        end
      end
      BK_TICK_ROM: mag_d = sine_rom[addr_q];
      BK_TICK_MUL: prod_d = (CMP_W + MAGW)'(cfg_i.max_compare) * (CMP_W + MAGW)'(mag_q);
      BK_TICK_FIN: next_cmp_d = cfg_i.max_compare - prod_q[CMP_W+MAGW-1:MAGW];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      low_q       <= MW'(LOW_RST);
      high_q      <= MW'(HIGH_RST);
      period_q    <= MIN_STEP_RST;
      phase_q     <= '0;
      next_cmp_q  <= MAX_CMP_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      low_q       <= low_d;
      high_q      <= high_d;
      period_q    <= period_d;
      phase_q     <= phase_d;
      next_cmp_q  <= next_cmp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ca_q     <= ca_d;
    cb_q     <= cb_d;
    steps_q  <= steps_d;
    sample_q <= sample_d;
    empty_q  <= empty_d;
    zero_q   <= zero_d;
    addr_q   <= addr_d;
    mag_q    <= mag_d;
    prod_q   <= prod_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_ca_o    = ca_q;
  assign out_cb_o    = cb_q;
  assign out_steps_o = steps_q;

endmodule

// ===== src/atsg_checker.sv =====
// Port-level checks of the generator, bound to the top level.
module atsg_checker import atsg_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [OUT_TDW-1:0] m_axis_tdata
);

  localparam int unsigned MAX_OPEN = 4;

  logic [2:0] open_q;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> open_q != 3'd0)
    else $error("output word without a pending input word");

  a_open_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= 3'(MAX_OPEN))
    else $error("more words in flight than the queue and stages hold");

endmodule

bind adc_tuned_sine_pwm_generator_top atsg_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
